/* hdl/pfsi_pkg.sv */
// ----------------------------------------------------------------------------
// pfsi_pkg: shared constants and types
// Widths, mode codes and the queue entry type of the spline path follower.
// ----------------------------------------------------------------------------
package pfsi_pkg;

  localparam int MaxPoints = 64;
  localparam int CoordBits = 32;
  localparam int TFracBits = 16;
  localparam int SlotBits  = 6;
  localparam int CntBits   = 7;
  localparam int SpeedBits = 24;
  localparam int DtBits    = 32;
  localparam int MaxWhole  = 255;

  // Interpolation mode codes.
  localparam logic [1:0] MODE_HOLD    = 2'd0;
  localparam logic [1:0] MODE_LINEAR  = 2'd1;
  localparam logic [1:0] MODE_CATMULL = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_SPEED   = 2'd0;
  localparam logic [1:0] REG_MODE    = 2'd1;
  localparam logic [1:0] REG_FORWARD = 2'd2;
  localparam logic [1:0] REG_COUNT   = 2'd3;

  // One classified tick handed from the front end to the back end.
  typedef struct packed {
    logic [7:0]           whole;
    logic [TFracBits-1:0] t_frac;
  } tick_t;

  // Floor of 1000.0 in Q16.16, saturated to the coordinate range.
  localparam logic [CoordBits-1:0] Z_SHORT = 32'd65536000;

endpackage

/* hdl/path_follower_spline_interp.sv */
// ----------------------------------------------------------------------------
// path_follower_spline_interp: Catmull-Rom / linear path follower
// Holds 3-D control points and reports a position on the path per tick.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries point writes (cmd=1), which give
// no result, and ticks (cmd=0), which give exactly one result transfer on
// the output channel (out_valid/out_stall).
// The front end registers the product of delta_time and speed and queues the
// new fraction and whole-unit count in a two-entry queue; it holds off the
// next item while a product is in flight or the queue is full.
// The back end steps the segment index once per whole unit (up to 255
// units), fetches two or four points from the table RAM over its read port,
// then runs the Horner loop per axis. In hold mode or on a short path it
// skips the fetch and the loop and goes straight to the result transfer;
// the front end's product register lies ahead of the queue.
// A point write is held off until every earlier tick has left the queue and
// the back end is idle; it is written to the table when it is accepted.
// Reset clears the fraction, the segment index and the last position and
// loads register defaults; the point table is not cleared.
// While out_stall is high the result holds and the back end waits; the
// front end keeps accepting ticks until its queue is full.
// ----------------------------------------------------------------------------
module path_follower_spline_interp (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [5:0]  point_slot,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic [31:0] point_z,
  input  logic [31:0] delta_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pos_x,
  output logic [31:0] pos_y,
  output logic [31:0] pos_z,
  output logic [5:0]  segment,
  output logic        too_short
);
  import pfsi_pkg::*;

  logic [SpeedBits-1:0]   speed;
  logic [1:0]             interp_mode;
  logic                   forwards;
  logic [CntBits-1:0]     point_count;
  logic                   pt_we;
  logic [SlotBits-1:0]    pt_waddr, pt_raddr;
  logic [3*CoordBits-1:0] pt_wdata, pt_rdata;
  logic                   q_valid, q_pop;
  logic                   busy;
  tick_t                  q_data;

  assign pready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed       <= SpeedBits'(65536);
      interp_mode <= MODE_HOLD;
      forwards    <= 1'b1;
      point_count <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_SPEED:   speed       <= pwdata[SpeedBits-1:0];
        REG_MODE:    interp_mode <= pwdata[1:0];
        REG_FORWARD: forwards    <= pwdata[0];
        REG_COUNT:   point_count <= pwdata[CntBits-1:0];
        default:     speed       <= speed;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[3:2])
      REG_SPEED:   prdata = {8'd0, speed};
      REG_MODE:    prdata = {30'd0, interp_mode};
      REG_FORWARD: prdata = {31'd0, forwards};
      REG_COUNT:   prdata = {25'd0, point_count};
      default:     prdata = '0;
    endcase
  end

  pfsi_front u_front (
    .clk, .rst, .in_valid, .in_stall, .cmd, .point_slot, .point_x, .point_y,
    .point_z, .delta_time, .speed, .busy, .pt_we, .pt_waddr, .pt_wdata,
    .q_valid, .q_data, .q_pop
  );

  pfsi_ram #(.Width(3*CoordBits), .Depth(MaxPoints)) u_table (
    .clk, .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  pfsi_back u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .busy, .interp_mode, .forwards,
    .point_count, .pt_raddr, .pt_rdata, .out_valid, .out_stall,
    .pos_x, .pos_y, .pos_z, .segment, .too_short
  );

endmodule

/* hdl/pfsi_ram.sv */
// ----------------------------------------------------------------------------
// pfsi_ram: generic two-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pfsi_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pfsi_front.sv */
// ----------------------------------------------------------------------------
// pfsi_front: tick front end
// Accepts items, writes points, advances the fraction and queues ticks.
// ----------------------------------------------------------------------------
module pfsi_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [pfsi_pkg::SlotBits-1:0]   point_slot,
  input  logic [pfsi_pkg::CoordBits-1:0]  point_x,
  input  logic [pfsi_pkg::CoordBits-1:0]  point_y,
  input  logic [pfsi_pkg::CoordBits-1:0]  point_z,
  input  logic [pfsi_pkg::DtBits-1:0]     delta_time,
  input  logic [pfsi_pkg::SpeedBits-1:0]  speed,
  input  logic                            busy,
  output logic                            pt_we,
  output logic [pfsi_pkg::SlotBits-1:0]   pt_waddr,
  output logic [3*pfsi_pkg::CoordBits-1:0] pt_wdata,
  output logic                            q_valid,
  output pfsi_pkg::tick_t                 q_data,
  input  logic                            q_pop
);
  import pfsi_pkg::*;

  localparam int ProdBits = DtBits + SpeedBits;

  // Stage 1 register: product of time and speed.
  logic                 p_valid;
  logic [ProdBits-1:0]  prod;
  logic [TFracBits-1:0] t_frac;
  logic [TFracBits-1:0] t_frac_next;
  logic [7:0]           whole_next;
  logic [ProdBits-TFracBits:0] sum;
  logic                 accept;

  // Two-entry queue toward the back end.
  tick_t                q_mem [2];
  logic                 q_wp, q_rp;
  logic [1:0]           q_cnt;

  // Stall while a product is in flight or the queue has no room for it.
  // A point write also waits until every earlier tick has read its points.
  assign in_stall = p_valid || (q_cnt == 2'd2) ||
                    (cmd && ((q_cnt != 2'd0) || busy));
  assign accept   = in_valid && !in_stall;

  assign pt_we    = accept && cmd;
  assign pt_waddr = point_slot;
  assign pt_wdata = {point_z, point_y, point_x};

  // Advance of the fraction and saturation of whole units.
  assign sum = {1'b0, prod[ProdBits-1:DtBits-TFracBits]} +
               {{(ProdBits-TFracBits-TFracBits+1){1'b0}}, t_frac};
  assign t_frac_next = sum[TFracBits-1:0];
  assign whole_next  = (sum[ProdBits-TFracBits:TFracBits] > MaxWhole) ? 8'(MaxWhole)
                       : sum[TFracBits+7:TFracBits];

  assign q_valid = (q_cnt != 2'd0);
  assign q_data  = q_mem[q_rp];

  // Product register, fraction state and queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      t_frac  <= '0;
      q_wp    <= 1'b0;
      q_rp    <= 1'b0;
      q_cnt   <= 2'd0;
    end else begin
      p_valid <= accept && !cmd;
      if (accept && !cmd) begin
        prod <= ProdBits'(delta_time) * ProdBits'(speed);
      end
      if (p_valid) begin
        t_frac <= t_frac_next;
        q_mem[q_wp] <= '{whole: whole_next, t_frac: t_frac_next};
        q_wp <= !q_wp;
      end
      if (q_pop) begin
        q_rp <= !q_rp;
      end
      q_cnt <= q_cnt + {1'b0, p_valid} - {1'b0, q_pop};
    end
  end

endmodule

/* hdl/pfsi_back.sv */
// ----------------------------------------------------------------------------
// pfsi_back: segment stepper and interpolator
// Steps the index, reads points and evaluates linear or Catmull-Rom sums.
// ----------------------------------------------------------------------------
module pfsi_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  pfsi_pkg::tick_t                  q_data,
  output logic                             q_pop,
  output logic                             busy,
  input  logic [1:0]                       interp_mode,
  input  logic                             forwards,
  input  logic [pfsi_pkg::CntBits-1:0]     point_count,
  output logic [pfsi_pkg::SlotBits-1:0]    pt_raddr,
  input  logic [3*pfsi_pkg::CoordBits-1:0] pt_rdata,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pfsi_pkg::CoordBits-1:0]   pos_x,
  output logic [pfsi_pkg::CoordBits-1:0]   pos_y,
  output logic [pfsi_pkg::CoordBits-1:0]   pos_z,
  output logic [pfsi_pkg::SlotBits-1:0]    segment,
  output logic                             too_short
);
  import pfsi_pkg::*;

  localparam int AccBits = CoordBits + 8;
  localparam int MulBits = AccBits + TFracBits + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_STEP  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_LOAD  = 7'b0001000,
    S_HORN  = 7'b0010000,
    S_NEXT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [SlotBits-1:0]  seg;
  logic [7:0]           whole;
  logic [TFracBits-1:0] t;
  logic [CntBits-1:0]   n;
  logic [1:0]           rcnt;     // points fetched so far
  logic [1:0]           hstep;    // Horner step
  logic [1:0]           axis;
  logic signed [CoordBits-1:0] pts [4][3];
  logic signed [CoordBits-1:0] last [3];
  logic signed [AccBits-1:0]   acc;
  logic                 shortp;
  logic                 linear;

  logic [CntBits-1:0]   limit;
  logic [CntBits-1:0]   seg_inc;
  logic signed [CoordBits-1:0] p0, p1, p2, p3;
  logic signed [AccBits-1:0]   k3, k2, k1, k0, addend;
  logic signed [MulBits-1:0]   prod;
  logic signed [AccBits-1:0]   acc_next;
  logic signed [AccBits-1:0]   half;
  logic signed [CoordBits-1:0] res;
  logic [1:0]                  pidx;

  assign n     = (point_count > CntBits'(MaxPoints)) ? CntBits'(MaxPoints) : point_count;
  assign limit = linear ? n - 7'd1 : n - 7'd3;
  assign seg_inc = {1'b0, seg} + 7'd1;

  // Point order for the current axis, reversed when running backwards.
  always_comb begin
    if (forwards) begin
      p0 = pts[0][axis]; p1 = pts[1][axis]; p2 = pts[2][axis]; p3 = pts[3][axis];
    end else if (linear) begin
      p0 = pts[1][axis]; p1 = pts[0][axis]; p2 = pts[0][axis]; p3 = pts[0][axis];
    end else begin
      p0 = pts[3][axis]; p1 = pts[2][axis]; p2 = pts[1][axis]; p3 = pts[0][axis];
    end
  end

  // Coefficients and one Horner step: acc*t floored, plus next coefficient.
  assign k3 = -AccBits'(p0) + 3*AccBits'(p1) - 3*AccBits'(p2) + AccBits'(p3);
  assign k2 = 2*AccBits'(p0) - 5*AccBits'(p1) + 4*AccBits'(p2) - AccBits'(p3);
  assign k1 = AccBits'(p2) - AccBits'(p0);
  assign k0 = 2*AccBits'(p1);
  always_comb begin
    case (hstep)
      2'd0:    addend = k2;
      2'd1:    addend = k1;
      default: addend = k0;
    endcase
  end
  assign prod     = MulBits'(acc) * $signed({1'b0, t});
  assign acc_next = AccBits'(prod >>> TFracBits) + addend;
  assign half     = acc >>> 1;
  assign res = linear ?
    ((acc > AccBits'(32'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
     (acc < -AccBits'(33'sh80000000)) ? 32'sh80000000 : CoordBits'(acc)) :
    ((half > AccBits'(32'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
     (half < -AccBits'(33'sh80000000)) ? 32'sh80000000 : CoordBits'(half));

  assign pidx  = rcnt - 2'd1;
  assign q_pop = (state == S_IDLE) && q_valid;
  assign busy  = (state != S_IDLE);
  assign pos_x = last[0];
  assign pos_y = last[1];
  assign pos_z = last[2];
  assign segment = seg;

  // Sequencer: whole-unit steps, point fetch, Horner evaluation per axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg       <= '0;
      out_valid <= 1'b0;
      too_short <= 1'b0;
      for (int j = 0; j < 3; j++) last[j] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            whole  <= q_data.whole;
            t      <= q_data.t_frac;
            linear <= (interp_mode == MODE_LINEAR);
            if (interp_mode == MODE_LINEAR) begin
              if (n < 7'd2) begin
                seg <= '0; shortp <= 1'b1; state <= S_OUT;
              end else begin
                shortp <= 1'b0;
                state  <= S_STEP;
              end
            end else if (interp_mode == MODE_CATMULL) begin
              if (n < 7'd4) begin
                seg <= SlotBits'(1); shortp <= 1'b1; state <= S_OUT;
              end else begin
                if (seg == '0) seg <= SlotBits'(1);
                shortp <= 1'b0;
                state  <= S_STEP;
              end
            end else begin
              shortp <= 1'b0;
              state  <= S_OUT;
            end
          end
        end
        S_STEP: begin
          if (whole != 8'd0) begin
            whole <= whole - 8'd1;
            seg <= (seg_inc >= limit) ? (linear ? '0 : SlotBits'(1)) : seg_inc[SlotBits-1:0];
          end else begin
            if ({1'b0, seg} >= limit) seg <= linear ? '0 : SlotBits'(1);
            rcnt  <= 2'd0;
            state <= S_READ;
          end
        end
        S_READ: begin
          rcnt <= rcnt + 2'd1;
          if (rcnt != 2'd0) begin
            for (int j = 0; j < 3; j++)
              pts[pidx][j] <= pt_rdata[j*CoordBits +: CoordBits];
          end
          if (rcnt == (linear ? 2'd1 : 2'd3)) state <= S_LOAD;
        end
        S_LOAD: begin
          for (int j = 0; j < 3; j++)
            pts[linear ? 2'd1 : 2'd3][j] <= pt_rdata[j*CoordBits +: CoordBits];
          axis  <= 2'd0;
          state <= S_NEXT;
        end
        S_NEXT: begin
          hstep <= linear ? 2'd2 : 2'd0;
          if (axis == 2'd3) begin
            state <= S_OUT;
          end else if (linear) begin
            acc   <= AccBits'(p1) - AccBits'(p0);
            state <= S_HORN;
          end else begin
            acc   <= k3;
            state <= S_HORN;
          end
        end
        S_HORN: begin
          if (linear) begin
            acc <= AccBits'(prod >>> TFracBits) + AccBits'(p0);
          end else begin
            acc <= acc_next;
          end
          hstep <= hstep + 2'd1;
          if (hstep == 2'd3) begin
            last[axis] <= res;
            axis  <= axis + 2'd1;
            state <= S_NEXT;
          end else begin
            state <= S_HORN;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            too_short <= shortp;
            if (shortp) last[2] <= Z_SHORT;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Table read address: segment plus the point offset being fetched.
  assign pt_raddr = linear ? seg + SlotBits'(rcnt)
                           : seg - SlotBits'(1) + SlotBits'(rcnt);

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the spline path follower
// Drives point writes and ticks over the input channel with random idling
// on both sides, changes the registers over the APB port between phases,
// and checks every position transfer against a behavioral predictor or a directed value.
// ----------------------------------------------------------------------------
module tb;
  import pfsi_pkg::*;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [5:0]  seg;
    logic        ts;
  } position_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  regsel;
    logic [31:0] value;
    logic        cmd;
    logic [5:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] dt;
    bit          typed;
    position_t   want;
  } step_row_t;

  localparam int WatchLimit = 20000;
  localparam int SettleCycles = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = 1'b0;
  logic [5:0]  point_slot = '0;
  logic [31:0] point_x = '0;
  logic [31:0] point_y = '0;
  logic [31:0] point_z = '0;
  logic [31:0] delta_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [5:0]  segment;
  logic        too_short;

  path_follower_spline_interp u_top (.*);

  always #6 clk = ~clk;

  // Predictor state and register shadows.
  longint      path_pts[MaxPoints][3];
  logic [15:0] pr_frac;
  int          pr_seg;
  longint      pr_last[3];
  logic [23:0] sh_speed;
  logic [1:0]  sh_mode;
  logic        sh_fwd;
  logic [6:0]  sh_count;

  position_t   pos_expected[$];
  int          errs = 0;
  int          ticks_seen = 0;
  int          writes_seen = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 0;
  bit          row_typed = 0;
  position_t   row_want;
  int          quiet_cycles = 0;
  bit          apb_hit = 0;

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint frac_mul(longint v, logic [15:0] t);
    return (v * longint'(t)) >>> 16;
  endfunction

  function automatic longint spline_axis(longint p0, longint p1, longint p2, longint p3,
                                         logic [15:0] t);
    longint acc;
    acc = -p0 + 3 * p1 - 3 * p2 + p3;
    acc = frac_mul(acc, t) + (2 * p0 - 5 * p1 + 4 * p2 - p3);
    acc = frac_mul(acc, t) + (p2 - p0);
    acc = frac_mul(acc, t) + 2 * p1;
    return clamp_coord(acc >>> 1);
  endfunction

  // Advances the path by one tick and returns the reported position.
  function automatic position_t follow_tick(logic [31:0] dt);
    logic [63:0] adv;
    logic [63:0] sum;
    int          whole;
    int          n;
    bit          short_path;
    position_t   p;
    short_path = 0;
    adv = (64'(dt) * 64'(sh_speed)) >> 16;
    sum = 64'(pr_frac) + adv;
    whole = (sum >> 16) > 64'd255 ? MaxWhole : int'(sum >> 16);
    pr_frac = sum[15:0];
    n = (sh_count > MaxPoints) ? MaxPoints : int'(sh_count);
    if (sh_mode == MODE_LINEAR) begin
      if (n >= 2) begin
        for (int k = 0; k < whole; k++) begin
          pr_seg++;
          if (pr_seg >= n - 1) pr_seg = 0;
        end
        if (pr_seg >= n - 1) pr_seg = 0;
        for (int j = 0; j < 3; j++) begin
          longint a;
          longint b;
          a = sh_fwd ? path_pts[pr_seg][j] : path_pts[pr_seg + 1][j];
          b = sh_fwd ? path_pts[pr_seg + 1][j] : path_pts[pr_seg][j];
          pr_last[j] = clamp_coord(a + frac_mul(b - a, pr_frac));
        end
      end else begin
        pr_seg = 0;
        short_path = 1;
      end
    end else if (sh_mode == MODE_CATMULL) begin
      if (n >= 4) begin
        if (pr_seg == 0) pr_seg = 1;
        for (int k = 0; k < whole; k++) begin
          pr_seg++;
          if (pr_seg >= n - 3) pr_seg = 1;
        end
        if (pr_seg >= n - 3) pr_seg = 1;
        for (int j = 0; j < 3; j++) begin
          longint q0;
          longint q1;
          longint q2;
          longint q3;
          q0 = path_pts[pr_seg - 1][j];
          q1 = path_pts[pr_seg][j];
          q2 = path_pts[pr_seg + 1][j];
          q3 = path_pts[pr_seg + 2][j];
          pr_last[j] = sh_fwd ? spline_axis(q0, q1, q2, q3, pr_frac)
                              : spline_axis(q3, q2, q1, q0, pr_frac);
        end
      end else begin
        pr_seg = 1;
        short_path = 1;
      end
    end
    if (short_path) pr_last[2] = longint'(signed'(Z_SHORT));
    p.x = pr_last[0][31:0];
    p.y = pr_last[1][31:0];
    p.z = pr_last[2][31:0];
    p.seg = pr_seg[5:0];
    p.ts = short_path;
    return p;
  endfunction

  // Input side: accepted transfers feed the predictor.
  // Output side: each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      if (cmd) begin
        path_pts[point_slot][0] = longint'(signed'(point_x));
        path_pts[point_slot][1] = longint'(signed'(point_y));
        path_pts[point_slot][2] = longint'(signed'(point_z));
        writes_seen++;
      end else begin
        position_t p;
        p = follow_tick(delta_time);
        pos_expected.push_back(row_typed ? row_want : p);
        ticks_seen++;
      end
    end
    if (!rst && out_valid && !out_stall) begin
      if (pos_expected.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h seg=%0d short=%b", $time,
                 pos_x, pos_y, pos_z, segment, too_short);
        errs++;
      end else begin
        position_t w;
        w = pos_expected.pop_front();
        if (pos_x !== w.x || pos_y !== w.y || pos_z !== w.z ||
            segment !== w.seg || too_short !== w.ts) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h seg=%0d short=%b", $time,
                   w.x, w.y, w.z, w.seg, w.ts);
          $display("%0t:          actual   x=%h y=%h z=%h seg=%0d short=%b", $time,
                   pos_x, pos_y, pos_z, segment, too_short);
          errs++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on any port.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || apb_hit) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d results outstanding", pos_expected.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stall, with an optional long hold-off.
  always @(negedge clk) begin
    if (hold_req) begin
      out_stall = 1'b1;
      repeat (500) @(negedge clk);
      hold_req = 0;
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic reg_write(logic [1:0] regsel, logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {regsel, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    apb_hit = 1;
    @(posedge clk);
    case (regsel)
      REG_SPEED:   sh_speed = value[23:0];
      REG_MODE:    sh_mode = value[1:0];
      REG_FORWARD: sh_fwd = value[0];
      default:     sh_count = value[6:0];
    endcase
    @(negedge clk);
    apb_hit = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Lets every expected result arrive, then lets trailing writes finish.
  task automatic drain();
    in_valid = 1'b0;
    while (pos_expected.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Offers one transfer on the input channel; called at a falling edge.
  task automatic send_item(logic c, logic [5:0] s, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cmd = c;
    point_slot = s;
    point_x = x;
    point_y = y;
    point_z = z;
    delta_time = dt;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic step_row_t cfg_row(logic [1:0] r, logic [31:0] v);
    step_row_t row;
    row = '{default: '0};
    row.is_cfg = 1;
    row.regsel = r;
    row.value = v;
    return row;
  endfunction

  function automatic step_row_t item_row(logic c, logic [5:0] s, logic [31:0] x,
                                         logic [31:0] y, logic [31:0] z,
                                         logic [31:0] dt);
    step_row_t row;
    row = '{default: '0};
    row.cmd = c;
    row.slot = s;
    row.x = x;
    row.y = y;
    row.z = z;
    row.dt = dt;
    return row;
  endfunction

  function automatic step_row_t typed_tick(logic [31:0] dt, logic [31:0] z, logic [5:0] seg,
                                          logic ts);
    step_row_t row;
    row = item_row(1'b0, '0, '0, '0, '0, dt);
    row.typed = 1;
    row.want = '{x: '0, y: '0, z: z, seg: seg, ts: ts};
    return row;
  endfunction

  function automatic logic [31:0] rand_dt();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(32'h3_FFFF);
      default: return $urandom_range(32'hFFFF);
    endcase
  endfunction

  step_row_t steps[$];

  initial begin
    pr_frac = '0;
    pr_seg = 0;
    pr_last = '{0, 0, 0};
    sh_speed = 24'd65536;
    sh_mode = MODE_HOLD;
    sh_fwd = 1'b1;
    sh_count = '0;
    foreach (path_pts[i]) path_pts[i] = '{0, 0, 0};
    repeat (4) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed part: hold mode after reset, short paths, extreme points.
    steps.push_back(typed_tick(32'd0, '0, 6'd0, 1'b0));
    steps.push_back(typed_tick(32'hFFFF_FFFF, '0, 6'd0, 1'b0));
    steps.push_back(cfg_row(REG_MODE, 32'(MODE_LINEAR)));
    steps.push_back(typed_tick(32'h0001_0000, Z_SHORT, 6'd0, 1'b1));
    steps.push_back(cfg_row(REG_MODE, 32'(MODE_CATMULL)));
    steps.push_back(cfg_row(REG_COUNT, 32'd3));
    steps.push_back(typed_tick(32'h0000_8000, Z_SHORT, 6'd1, 1'b1));
    steps.push_back(item_row(1'b1, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'd0));
    steps.push_back(item_row(1'b1, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                             32'd0));
    steps.push_back(item_row(1'b1, 6'd2, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                             32'd0));
    steps.push_back(item_row(1'b1, 6'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'd0));
    steps.push_back(item_row(1'b1, 6'd4, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678,
                             32'd0));
    steps.push_back(item_row(1'b1, 6'd5, 32'hFFFF_FFFF, 32'h0000_0001, 32'hDEAD_BEEF,
                             32'd0));
    steps.push_back(cfg_row(REG_COUNT, 32'd6));
    steps.push_back(item_row(1'b0, '0, '0, '0, '0, 32'h0000_8000));
    steps.push_back(item_row(1'b0, '0, '0, '0, '0, 32'h0001_8000));
    steps.push_back(cfg_row(REG_FORWARD, 32'd0));
    steps.push_back(item_row(1'b0, '0, '0, '0, '0, 32'hFFFF_FFFF));
    steps.push_back(cfg_row(REG_MODE, 32'(MODE_LINEAR)));
    steps.push_back(item_row(1'b0, '0, '0, '0, '0, 32'h0000_4000));
    steps.push_back(item_row(1'b0, '0, '0, '0, '0, 32'h0002_0000));
    steps.push_back(cfg_row(REG_FORWARD, 32'd1));
    steps.push_back(cfg_row(REG_SPEED, 32'h00FF_FFFF));
    steps.push_back(item_row(1'b0, '0, '0, '0, '0, 32'hFFFF_FFFF));
    steps.push_back(cfg_row(REG_SPEED, 32'd0));
    steps.push_back(item_row(1'b0, '0, '0, '0, '0, 32'h0001_2345));
    steps.push_back(cfg_row(REG_MODE, 32'd3));
    steps.push_back(item_row(1'b0, '0, '0, '0, '0, 32'h0003_0000));

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        drain();
        reg_write(steps[i].regsel, steps[i].value);
      end else begin
        row_typed = steps[i].typed;
        row_want = steps[i].want;
        send_item(steps[i].cmd, steps[i].slot, steps[i].x, steps[i].y, steps[i].z,
                  steps[i].dt);
      end
    end
    drain();
    row_typed = 0;

    // Fill the whole table so that every point count reads written slots.
    for (int s = 0; s < MaxPoints; s++) begin
      send_item(1'b1, s[5:0], $urandom, $urandom, $urandom, $urandom);
    end

    // Random part: three idling profiles, four register settings each.
    for (int prof = 0; prof < 3; prof++) begin
      send_idle_pct = (prof == 0) ? 23 : (prof == 1) ? 81 : 0;
      recv_idle_pct = (prof == 0) ? 81 : (prof == 1) ? 23 : 0;
      for (int ph = 0; ph < 4; ph++) begin
        logic [31:0] spd;
        logic [31:0] cnt;
        drain();
        case ($urandom_range(3))
          0:       spd = 32'h00FF_FFFF;
          1:       spd = 32'd0;
          2:       spd = 32'd65536;
          default: spd = $urandom_range(24'hFF_FFFF);
        endcase
        case ($urandom_range(5))
          0:       cnt = $urandom_range(3);
          1:       cnt = 32'd64;
          2:       cnt = $urandom_range(65, 127);
          default: cnt = $urandom_range(4, 64);
        endcase
        reg_write(REG_SPEED, spd);
        reg_write(REG_MODE, (ph == 3) ? $urandom_range(3) : 32'(ph == 0 ? 2 : ph));
        reg_write(REG_FORWARD, $urandom_range(1));
        reg_write(REG_COUNT, cnt);
        if (prof == 2 && ph == 0) hold_req = 1;
        for (int k = 0; k < 75; k++) begin
          if ($urandom_range(99) < 15) begin
            send_item(1'b1, 6'($urandom_range(63)), $urandom, $urandom, $urandom,
                      $urandom);
          end else begin
            send_item(1'b0, 6'($urandom_range(63)), $urandom, $urandom, $urandom,
                      rand_dt());
          end
        end
      end
    end
    drain();

    $display("Covered %0d ticks and %0d point writes over hold, linear and spline modes,",
             ticks_seen, writes_seen);
    $display("with short paths, saturated advances and three idling profiles.");
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
